>>> hdl/gmsc_pkg.sv
// shared widths, codes and defaults of the stack-driven maze carver
`default_nettype none

package gmsc_pkg;

    // default sizes of the grid and of the stack
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_STACK_DEPTH = 2048;

    // payload field widths
    localparam int MODE_W     = 2;
    localparam int COORD_W    = 6;
    localparam int CNT_W      = 3;
    localparam int DEPTH_W    = 12;
    localparam int STATUS_W   = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int GRID_W     = 7;
    localparam int START_W    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd3;

    localparam logic [GRID_W-1:0]  GRID_RESET  = 7'd64;
    localparam logic [START_W-1:0] START_RESET = 6'd0;

    // transaction modes
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_START_OUT = 2'd2;

endpackage

`default_nettype wire

>>> hdl/gmsc_if.sv
// valid/ready channel interfaces for the carver's request and result streams
`default_nettype none

interface gmsc_in_if import gmsc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;

    modport source (output valid, output mode, output cell_col, output cell_row,
                    input ready);
    modport sink   (input valid, input mode, input cell_col, input cell_row,
                    output ready);
endinterface

interface gmsc_out_if import gmsc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                done_flag;
    logic                cell_open;
    logic [CNT_W-1:0]    carved_count;
    logic [DEPTH_W-1:0]  depth_now;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output done_flag, output cell_open,
                    output carved_count, output depth_now, output status,
                    input ready);
    modport sink   (input valid, input done_flag, input cell_open,
                    input carved_count, input depth_now, input status,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/grid_maze_stack_carver_core.sv
// maze carver top level: grid memory, cell stack memory and step sequencer
// a carve step pops a cell and tries the neighbors left, up, right, down; a
//   skipped or already open neighbor is passed over, one carved sideways is
//   written in its own row, one carved up or down also rewrites the halfway row
// throughput: one transaction at a time, paced by the single-port grid memory
// reset: a clearing pass writes every grid row to walls, input not ready
//   meanwhile; configuration writes are taken at any time
`default_nettype none

module grid_maze_stack_carver_core
    import gmsc_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    gmsc_in_if.sink                    in_ch,
    gmsc_out_if.source                 out_ch,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // coordinate widths and compare widths (wide enough for grid regs and +2)
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CXW = (CW + 1 > GRID_W) ? CW + 1 : GRID_W;
    localparam int RXW = (RW + 1 > GRID_W) ? RW + 1 : GRID_W;
    localparam int SEW = CW + RW;
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    localparam logic [MAX_COLS-1:0] COL_ONE  = MAX_COLS'(1);
    localparam logic [RW-1:0]       LAST_ROW = RW'(MAX_ROWS - 1);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CLEAR   = 8'b0000_0010,
        S_NB      = 8'b0000_0100,
        S_EVAL    = 8'b0000_1000,
        S_HALF_RD = 8'b0001_0000,
        S_HALF_WR = 8'b0010_0000,
        S_RDCELL  = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } state_t;

    // neighbor visiting order
    typedef enum logic [1:0] {
        NB_LEFT  = 2'd0,
        NB_UP    = 2'd1,
        NB_RIGHT = 2'd2,
        NB_DOWN  = 2'd3
    } nb_dir_t;

    // control state
    state_t              state_reg, state_next;
    logic                boot_reg, boot_next;
    logic [RW-1:0]       clr_reg, clr_next;
    nb_dir_t             k_reg, k_next;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic                fin_reg, fin_next;
    logic                out_valid_reg, out_valid_next;

    // per-transaction working values
    logic [CNT_W-1:0]    carved_reg, carved_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                open_reg, open_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [CW-1:0]       rd_col_reg, rd_col_next;
    logic [CW-1:0]       nx_reg, nx_next;
    logic [RW-1:0]       ny_reg, ny_next;
    logic [CW-1:0]       hx_reg, hx_next;
    logic [RW-1:0]       hy_reg, hy_next;
    logic                vert_reg, vert_next;

    // result register
    logic                out_done_reg;
    logic                out_open_reg;
    logic [CNT_W-1:0]    out_carved_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_load;

    // configuration registers
    logic [GRID_W-1:0]   grid_cols_reg;
    logic [GRID_W-1:0]   grid_rows_reg;
    logic [START_W-1:0]  start_col_reg;
    logic [START_W-1:0]  start_row_reg;

    // grid memory: one row of cells per entry
    logic [MAX_COLS-1:0] map_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] map_rd_reg;
    logic                map_we, map_re;
    logic [RW-1:0]       map_addr;
    logic [MAX_COLS-1:0] map_wdata;

    // cell stack memory: {row, col} per entry
    logic [SEW-1:0]      stk_mem [STACK_DEPTH];
    logic [SEW-1:0]      stk_rd_reg;
    logic                stk_we, stk_re;
    logic [SIW-1:0]      stk_addr;
    logic [SEW-1:0]      stk_wdata;

    // popped cell and neighbor geometry
    logic [CW-1:0]       cur_x;
    logic [RW-1:0]       cur_y;
    logic [CW:0]         nx_c, hx_c;
    logic [RW:0]         ny_c, hy_c;
    logic                nb_ok;
    logic                nb_in;
    logic                vert_c;

    logic                in_acc;
    logic                start_in;
    logic                read_in;
    logic [SPW-1:0]      sp_dec;
    logic                nb_last;
    state_t              after_nb;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.done_flag    = out_done_reg;
    assign out_ch.cell_open    = out_open_reg;
    assign out_ch.carved_count = out_carved_reg;
    assign out_ch.depth_now    = out_depth_reg;
    assign out_ch.status       = out_status_reg;

    assign cur_x  = stk_rd_reg[CW-1:0];
    assign cur_y  = stk_rd_reg[SEW-1:CW];
    assign sp_dec = sp_reg - SPW'(1);

    // start cell and read cell must lie inside the active grid
    assign start_in = (CXW'(start_col_reg) < CXW'(grid_cols_reg))
                   && (CXW'(start_col_reg) < CXW'(MAX_COLS))
                   && (RXW'(start_row_reg) < RXW'(grid_rows_reg))
                   && (RXW'(start_row_reg) < RXW'(MAX_ROWS));
    assign read_in  = (CXW'(in_ch.cell_col) < CXW'(grid_cols_reg))
                   && (CXW'(in_ch.cell_col) < CXW'(MAX_COLS))
                   && (RXW'(in_ch.cell_row) < RXW'(grid_rows_reg))
                   && (RXW'(in_ch.cell_row) < RXW'(MAX_ROWS));

    // neighbor two cells away and the halfway cell, for the current direction
    always_comb
    begin
        nx_c   = {1'b0, cur_x};
        hx_c   = {1'b0, cur_x};
        ny_c   = {1'b0, cur_y};
        hy_c   = {1'b0, cur_y};
        nb_ok  = 1'b1;
        vert_c = 1'b0;
        case (k_reg)
            NB_LEFT:
            begin
                nb_ok = (cur_x >= CW'(2));
                nx_c  = {1'b0, cur_x} - (CW + 1)'(2);
                hx_c  = {1'b0, cur_x} - (CW + 1)'(1);
            end
            NB_UP:
            begin
                nb_ok  = (cur_y >= RW'(2));
                ny_c   = {1'b0, cur_y} - (RW + 1)'(2);
                hy_c   = {1'b0, cur_y} - (RW + 1)'(1);
                vert_c = 1'b1;
            end
            NB_RIGHT:
            begin
                nx_c = {1'b0, cur_x} + (CW + 1)'(2);
                hx_c = {1'b0, cur_x} + (CW + 1)'(1);
            end
            NB_DOWN:
            begin
                ny_c   = {1'b0, cur_y} + (RW + 1)'(2);
                hy_c   = {1'b0, cur_y} + (RW + 1)'(1);
                vert_c = 1'b1;
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // current grid size may have shrunk since the cell was pushed
    assign nb_in = nb_ok
                && (CXW'(nx_c) < CXW'(grid_cols_reg)) && (CXW'(nx_c) < CXW'(MAX_COLS))
                && (RXW'(ny_c) < RXW'(grid_rows_reg)) && (RXW'(ny_c) < RXW'(MAX_ROWS));

    assign nb_last  = (k_reg == NB_DOWN);
    assign after_nb = nb_last ? S_FIN : S_NB;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        boot_next      = boot_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        sp_next        = sp_reg;
        fin_next       = fin_reg;
        carved_next    = carved_reg;
        status_next    = status_reg;
        open_next      = open_reg;
        rd_ok_next     = rd_ok_reg;
        rd_col_next    = rd_col_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        hx_next        = hx_reg;
        hy_next        = hy_reg;
        vert_next      = vert_reg;
        out_load       = 1'b0;
        map_we         = 1'b0;
        map_re         = 1'b0;
        map_addr       = '0;
        map_wdata      = '0;
        stk_we         = 1'b0;
        stk_re         = 1'b0;
        stk_addr       = '0;
        stk_wdata      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    carved_next = '0;
                    status_next = ST_OK;
                    open_next   = 1'b0;
                    case (in_ch.mode)
                        MODE_RESTART:
                        begin
                            fin_next = 1'b0;
                            clr_next = '0;
                            // the start cell goes on the stack but stays a wall
                            if (start_in)
                            begin
                                stk_we    = 1'b1;
                                stk_addr  = '0;
                                stk_wdata = {RW'(start_row_reg), CW'(start_col_reg)};
                                sp_next   = SPW'(1);
                            end
                            else
                            begin
                                sp_next     = '0;
                                status_next = ST_START_OUT;
                            end
                            state_next = S_CLEAR;
                        end
                        MODE_STEP:
                        begin
                            if (sp_reg == '0)
                            begin
                                fin_next   = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                // pop: data shows up in stk_rd_reg next cycle
                                stk_re     = 1'b1;
                                stk_addr   = sp_dec[SIW-1:0];
                                sp_next    = sp_dec;
                                k_next     = NB_LEFT;
                                state_next = S_NB;
                            end
                        end
                        MODE_READ:
                        begin
                            map_re      = 1'b1;
                            map_addr    = RW'(in_ch.cell_row);
                            rd_ok_next  = read_in;
                            rd_col_next = CW'(in_ch.cell_col);
                            state_next  = S_RDCELL;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_addr  = clr_reg;
                map_wdata = '0;
                clr_next  = clr_reg + RW'(1);
                if (clr_reg == LAST_ROW)
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_FIN;
                end
            end
            S_NB:
            begin
                if (nb_in)
                begin
                    map_re     = 1'b1;
                    map_addr   = RW'(ny_c);
                    nx_next    = CW'(nx_c);
                    ny_next    = RW'(ny_c);
                    hx_next    = CW'(hx_c);
                    hy_next    = RW'(hy_c);
                    vert_next  = vert_c;
                    state_next = S_EVAL;
                end
                else
                begin
                    k_next     = nb_dir_t'(k_reg + 2'd1);
                    state_next = after_nb;
                end
            end
            S_EVAL:
            begin
                if (!map_rd_reg[nx_reg])
                begin
                    // horizontal: halfway cell shares the row, one write covers both
                    map_we      = 1'b1;
                    map_addr    = ny_reg;
                    map_wdata   = map_rd_reg | (COL_ONE << nx_reg)
                                | (vert_reg ? '0 : (COL_ONE << hx_reg));
                    carved_next = carved_reg + CNT_W'(1);
                    if (sp_reg < SPW'(STACK_DEPTH))
                    begin
                        stk_we    = 1'b1;
                        stk_addr  = sp_reg[SIW-1:0];
                        stk_wdata = {ny_reg, nx_reg};
                        sp_next   = sp_reg + SPW'(1);
                    end
                    else
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    if (vert_reg)
                    begin
                        state_next = S_HALF_RD;
                    end
                    else
                    begin
                        k_next     = nb_dir_t'(k_reg + 2'd1);
                        state_next = after_nb;
                    end
                end
                else
                begin
                    k_next     = nb_dir_t'(k_reg + 2'd1);
                    state_next = after_nb;
                end
            end
            S_HALF_RD:
            begin
                map_re     = 1'b1;
                map_addr   = hy_reg;
                state_next = S_HALF_WR;
            end
            S_HALF_WR:
            begin
                map_we     = 1'b1;
                map_addr   = hy_reg;
                map_wdata  = map_rd_reg | (COL_ONE << hx_reg);
                k_next     = nb_dir_t'(k_reg + 2'd1);
                state_next = after_nb;
            end
            S_RDCELL:
            begin
                open_next  = rd_ok_reg && map_rd_reg[rd_col_reg];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // result register free or being emptied this cycle
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers; reset starts the grid clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            boot_reg      <= 1'b1;
            clr_reg       <= '0;
            k_reg         <= NB_LEFT;
            sp_reg        <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            sp_reg        <= sp_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= GRID_RESET;
            grid_rows_reg <= GRID_RESET;
            start_col_reg <= START_RESET;
            start_row_reg <= START_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_GRID_COLS: grid_cols_reg <= cfg_data[GRID_W-1:0];
                CFG_GRID_ROWS: grid_rows_reg <= cfg_data[GRID_W-1:0];
                CFG_START_COL: start_col_reg <= cfg_data[START_W-1:0];
                CFG_START_ROW: start_row_reg <= cfg_data[START_W-1:0];
                default:       ;
            endcase
        end
    end

    // working values and result payload
    always_ff @(posedge clk)
    begin
        carved_reg <= carved_next;
        status_reg <= status_next;
        open_reg   <= open_next;
        rd_ok_reg  <= rd_ok_next;
        rd_col_reg <= rd_col_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        hx_reg     <= hx_next;
        hy_reg     <= hy_next;
        vert_reg   <= vert_next;
        if (out_load)
        begin
            out_done_reg   <= fin_reg;
            out_open_reg   <= open_reg;
            out_carved_reg <= carved_reg;
            out_depth_reg  <= DEPTH_W'(sp_reg);
            out_status_reg <= status_reg;
        end
    end

    // grid memory, single port, registered read
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_addr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rd_reg <= map_mem[map_addr];
        end
    end

    // stack memory, single port, registered read
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_addr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_addr];
        end
    end

endmodule

`default_nettype wire
